// File: src/grld_pkg.sv
package grld_pkg;

   localparam int unsigned HeaderLen  = 8;
   localparam int unsigned HdrCntW    = $clog2(HeaderLen + 1);
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
   localparam int unsigned RspDataW   = 88;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT_HEADER = 3'd1,
      ST_ZERO_SIZE    = 3'd2,
      ST_ZERO_RUN     = 3'd3,
      ST_SHORTFALL    = 3'd4
   } status_type;

   typedef enum logic {
      KIND_RUN    = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // one queued request outcome: an optional run, then an optional status
   typedef struct packed {
      logic        has_run;
      logic [7:0]  pixel_value;
      logic [7:0]  run_count;
      logic        has_status;
      status_type  status_code;
      logic [31:0] image_width;
      logic [31:0] image_height;
   } entry_type;

endpackage

// File: src/grld_front.sv
module grld_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                queue_full,
   output logic                push,
   output grld_pkg::entry_type push_entry
);

   logic [grld_pkg::HdrCntW-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [31:0]                  width_ff, width_in;
   logic [31:0]                  height_ff, height_in;
   logic [63:0]                  rem_ff, rem_in;
   logic                         mul_pend_ff, mul_pend_in;
   logic                         phase_ff, phase_in;
   logic [7:0]                   held_ff, held_in;
   grld_pkg::status_type         err_ff, err_in;

   logic        accept;
   logic        hdr_done;
   logic        hdr_last;
   logic        rem_nz;
   logic [2:0]  idx;
   logic [31:0] height_full;
   logic [63:0] product;
   logic [7:0]  cnt;

   assign req_tready  = !queue_full;
   assign accept      = req_tvalid && req_tready;
   assign hdr_done    = (hdr_cnt_ff == grld_pkg::HdrCntW'(grld_pkg::HeaderLen));
   assign idx         = hdr_cnt_ff[2:0];
   assign height_full = {req_tdata, height_ff[23:0]};
   assign product     = width_ff * height_ff;
   // remaining count loads in the cycle after the header; treat as nonzero meanwhile
   assign rem_nz      = mul_pend_ff || (rem_ff != 64'd0);

   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      rem_in      = rem_ff;
      mul_pend_in = mul_pend_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      err_in      = err_ff;
      hdr_last    = 1'b0;
      cnt         = 8'd0;
      push_entry  = '0;

      if (mul_pend_ff) begin
         rem_in      = product;
         mul_pend_in = 1'b0;
      end

      if (accept) begin
         if (!hdr_done) begin
            if (!idx[2]) begin
               width_in[{idx[1:0], 3'b000} +: 8] = req_tdata;
            end else begin
               height_in[{idx[1:0], 3'b000} +: 8] = req_tdata;
            end
            hdr_cnt_in = hdr_cnt_ff + 1'b1;
            if (idx == 3'd7) begin
               hdr_last = 1'b1;
               if ((width_ff == 32'd0) || (height_full == 32'd0)) begin
                  err_in = grld_pkg::ST_ZERO_SIZE;
               end else begin
                  mul_pend_in = 1'b1;
               end
            end
         end else if ((err_ff == grld_pkg::ST_OK) && rem_nz) begin
            if (!phase_ff) begin
               held_in  = req_tdata;
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (req_tdata == 8'd0) begin
                  err_in = grld_pkg::ST_ZERO_RUN;
               end else begin
                  // clamp to pixels still missing
                  if ((rem_ff[63:8] == 56'd0) && (rem_ff[7:0] < req_tdata)) begin
                     cnt = rem_ff[7:0];
                  end else begin
                     cnt = req_tdata;
                  end
                  rem_in                 = rem_ff - {56'd0, cnt};
                  push_entry.has_run     = 1'b1;
                  push_entry.pixel_value = held_ff;
                  push_entry.run_count   = cnt;
               end
            end
         end

         if (req_tlast) begin
            push_entry.has_status = 1'b1;
            if (!hdr_done && !hdr_last) begin
               push_entry.status_code = grld_pkg::ST_SHORT_HEADER;
            end else if (err_in != grld_pkg::ST_OK) begin
               push_entry.status_code = err_in;
            end else if (hdr_last || (rem_in != 64'd0)) begin
               push_entry.status_code = grld_pkg::ST_SHORTFALL;
            end else begin
               push_entry.status_code  = grld_pkg::ST_OK;
               push_entry.image_width  = width_ff;
               push_entry.image_height = height_ff;
            end
            // start over for the next stream
            hdr_cnt_in  = '0;
            width_in    = 32'd0;
            height_in   = 32'd0;
            rem_in      = 64'd0;
            mul_pend_in = 1'b0;
            phase_in    = 1'b0;
            held_in     = 8'd0;
            err_in      = grld_pkg::ST_OK;
         end
      end

      push = accept && (push_entry.has_run || push_entry.has_status);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         width_ff    <= 32'd0;
         height_ff   <= 32'd0;
         rem_ff      <= 64'd0;
         mul_pend_ff <= 1'b0;
         phase_ff    <= 1'b0;
         held_ff     <= 8'd0;
         err_ff      <= grld_pkg::ST_OK;
      end else begin
         hdr_cnt_ff  <= hdr_cnt_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         rem_ff      <= rem_in;
         mul_pend_ff <= mul_pend_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         err_ff      <= err_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_err_after_header: assert property (@(posedge clock) disable iff (reset)
      (err_ff != grld_pkg::ST_OK) |->
      (hdr_cnt_ff == grld_pkg::HdrCntW'(grld_pkg::HeaderLen)))
      else $error("error latched before header complete");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (push && push_entry.has_run) |-> (push_entry.run_count != 8'd0))
      else $error("zero-length run queued");
`endif

endmodule

// File: src/grld_queue.sv
module grld_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  grld_pkg::entry_type push_entry,
   input  logic                pop,
   output grld_pkg::entry_type head,
   output logic                head_valid,
   output logic                full
);

   grld_pkg::entry_type            mem_ff [grld_pkg::QueueDepth];
   logic [grld_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [grld_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [grld_pkg::QueueCntW-1:0] count_ff, count_in;

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == grld_pkg::QueueCntW'(grld_pkg::QueueDepth));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
`endif

endmodule

// File: src/grld_back.sv
module grld_back (
   input  logic                         clock,
   input  logic                         reset,
   input  grld_pkg::entry_type          head,
   input  logic                         head_valid,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [grld_pkg::RspDataW-1:0] rsp_tdata,
   output logic                         rsp_tuser,
   output logic                         rsp_tlast
);

   logic                          valid_ff, valid_in;
   logic                          second_ff, second_in;
   grld_pkg::kind_type            kind_ff, kind_in;
   logic [grld_pkg::RspDataW-1:0] data_ff, data_in;
   logic                          last_ff, last_in;
   logic                          load;

   assign load = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      kind_in   = kind_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      pop       = 1'b0;

      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end

      if (load) begin
         valid_in = 1'b1;
         if (head.has_run && !second_ff) begin
            kind_in = grld_pkg::KIND_RUN;
            data_in = {5'd0, 32'd0, 32'd0, 3'd0, head.run_count, head.pixel_value};
            last_in = 1'b0;
            if (head.has_status) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            kind_in   = grld_pkg::KIND_STATUS;
            data_in   = {5'd0, head.image_height, head.image_width, head.status_code,
                         8'd0, 8'd0};
            last_in   = 1'b1;
            second_in = 1'b0;
            pop       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
         kind_ff   <= grld_pkg::KIND_RUN;
         last_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
         kind_ff   <= kind_in;
         last_ff   <= last_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

`ifndef NO_ASSERTIONS
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("final flag and result kind disagree");
`endif

endmodule

// File: src/gray_run_length_decoder.sv
// Path: an accepted request is written to a queue entry, then loaded into the output
//   register; a last byte that also closes a run yields two results back to back.
// Throughput: one request per cycle while the queue is not full; results leave the
//   output register at one per cycle while rsp_tready is high, the run before the status.
// Reset: synchronous, active high; clears the parser state, the 4-entry queue and
//   the output register. The request carrying tlast also returns the parser to reset.
module gray_run_length_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic        req_tlast,   // end_of_stream
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [7:0] pixel_value, [15:8] run_count,
                                    // [18:16] status_code, [50:19] image_width,
                                    // [82:51] image_height, [87:83] zero
   output logic        rsp_tuser,   // result_kind: 0 run, 1 status
   output logic        rsp_tlast    // final_item
);

   // Front parses the byte stream: header assembly, pairing, run clamping and
   // error tracking. Its outcome per request (run and/or status) goes into a
   // small queue, so the parser keeps taking a byte every cycle until the queue
   // fills while the back end waits on rsp_tready.
   logic                queue_full;
   logic                push;
   grld_pkg::entry_type push_entry;

   // Back end unpacks each queued outcome into one or two result beats.
   grld_pkg::entry_type head;
   logic                head_valid;
   logic                pop;

   grld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   grld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   grld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // random part length, counted in requests that the decoder acts on
   localparam int unsigned LiveTarget  = 400;
   // no idling on either side for the final stretch of requests
   localparam int unsigned QuietTail   = 60;
   // extra cycles after the last expected result, to catch stray results
   localparam int unsigned DrainCycles = 16;

   // one expected result, fields as carried on the rsp channel
   typedef struct packed {
      grld_pkg::kind_type   kind;
      logic [7:0]           gray;
      logic [7:0]           count;
      grld_pkg::status_type status;
      logic [31:0]          width;
      logic [31:0]          height;
      logic                 fin;
   } decoded_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = 8'h00;   // [7:0] code_byte
   logic                          req_tlast  = 1'b0;    // end_of_stream
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [grld_pkg::RspDataW-1:0] rsp_tdata;   // [7:0] gray, [15:8] count, [18:16] status,
                                               // [50:19] width, [82:51] height,
                                               // [87:83] zero
   logic                          rsp_tuser;   // result_kind
   logic                          rsp_tlast;   // final_item

   gray_run_length_decoder DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Decoder prediction: private copy of the parser state
   // ---------------------------------------------------------------
   int unsigned          hdr_taken   = 0;
   logic [31:0]          hdr_width   = '0;
   logic [31:0]          hdr_height  = '0;
   logic [63:0]          pixel_goal  = '0;
   logic [63:0]          pixels_out  = '0;
   bit                   need_run    = 1'b0;   // 1: next byte is a run length
   logic [7:0]           held_gray   = '0;
   grld_pkg::status_type first_error = grld_pkg::ST_OK;

   decoded_type expected_out [$];     // results still owed by the decoder

   // bookkeeping
   int unsigned errors       = 0;
   int unsigned live_items   = 0;     // requests that changed state or produced output
   int unsigned sent_items   = 0;
   int unsigned streams      = 0;
   int unsigned runs_checked = 0;
   int unsigned status_seen [5];
   bit          quiet        = 1'b0;  // set near the end: no idling anywhere
   int unsigned gap_odds     = 0;     // sender idles with chance 1/gap_odds, 0 = never

   // add one owed result at the tail of the expected list
   function automatic void owe_result(input decoded_type r);
      expected_out = {expected_out, r};
   endfunction

   // Apply one accepted request to the model and queue what it must produce.
   // Returns 1 if the request was not simply ignored.
   function automatic bit decode_byte(input logic [7:0] b, input logic last);
      logic [63:0] left;
      logic [7:0]  cnt;
      decoded_type r;
      bit          used;
      used = 1'b0;
      if (hdr_taken < grld_pkg::HeaderLen) begin
         // header: width then height, little-endian
         used = 1'b1;
         if (hdr_taken < 4) hdr_width[8*hdr_taken +: 8] = b;
         else hdr_height[8*(hdr_taken-4) +: 8] = b;
         hdr_taken++;
         if (hdr_taken == grld_pkg::HeaderLen) begin
            pixel_goal = {32'b0, hdr_width} * {32'b0, hdr_height};
            if (pixel_goal == 0) first_error = grld_pkg::ST_ZERO_SIZE;
         end
      end else if (first_error == grld_pkg::ST_OK && pixels_out < pixel_goal) begin
         used = 1'b1;
         if (!need_run) begin
            held_gray = b;
            need_run  = 1'b1;
         end else begin
            need_run = 1'b0;
            if (b == 8'd0) begin
               first_error = grld_pkg::ST_ZERO_RUN;
            end else begin
               // clamp the run to what is still missing
               left = pixel_goal - pixels_out;
               cnt  = ({56'b0, b} < left) ? b : left[7:0];
               pixels_out += cnt;
               r       = '0;
               r.kind  = grld_pkg::KIND_RUN;
               r.gray  = held_gray;
               r.count = cnt;
               r.status = grld_pkg::ST_OK;
               owe_result(r);
            end
         end
      end
      if (last) begin
         used   = 1'b1;
         r      = '0;
         r.kind = grld_pkg::KIND_STATUS;
         r.fin  = 1'b1;
         if (hdr_taken < grld_pkg::HeaderLen) r.status = grld_pkg::ST_SHORT_HEADER;
         else if (first_error != grld_pkg::ST_OK) r.status = first_error;
         else if (pixels_out != pixel_goal) r.status = grld_pkg::ST_SHORTFALL;
         else begin
            r.status = grld_pkg::ST_OK;
            r.width  = hdr_width;
            r.height = hdr_height;
         end
         owe_result(r);
         // end of stream puts the parser back to its reset state
         hdr_taken   = 0;
         hdr_width   = '0;
         hdr_height  = '0;
         pixel_goal  = '0;
         pixels_out  = '0;
         need_run    = 1'b0;
         held_gray   = '0;
         first_error = grld_pkg::ST_OK;
      end
      return used;
   endfunction

   // ---------------------------------------------------------------
   // Result side: random backpressure and checking
   // ---------------------------------------------------------------
   int unsigned stall_left = 0;
   int unsigned stall_odds = 0;
   int unsigned rx_cycle   = 0;
   decoded_type head;

   // tready drops in bursts of random length; the burst rate is redrawn as rx_cycle
   // advances and can come out zero, so there are also long stretches with no stalls at all
   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_odds = $urandom_range(0, 3) * 4;
      if (stall_left > 0) stall_left--;
      else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
         stall_left = $urandom_range(1, 11);
      rsp_tready <= (stall_left == 0);
   end

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] act);
      if (exp !== act) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp, act);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_out.size() == 0) begin
            $error("result with none expected: tuser %0b tlast %0b tdata %0h",
                   rsp_tuser, rsp_tlast, rsp_tdata);
            errors++;
         end else begin
            head = expected_out.pop_front();
            check_field("result_kind",  32'(head.kind),   32'(rsp_tuser));
            check_field("pixel_value",  32'(head.gray),   32'(rsp_tdata[7:0]));
            check_field("run_count",    32'(head.count),  32'(rsp_tdata[15:8]));
            check_field("status_code",  32'(head.status), 32'(rsp_tdata[18:16]));
            check_field("image_width",  head.width,       rsp_tdata[50:19]);
            check_field("image_height", head.height,      rsp_tdata[82:51]);
            check_field("final_item",   32'(head.fin),    32'(rsp_tlast));
            check_field("tdata_pad",    32'd0,            32'(rsp_tdata[87:83]));
            if (head.kind == grld_pkg::KIND_RUN) runs_checked++;
            else status_seen[head.status]++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Present one byte and hold it until the decoder takes it. tvalid is
   // left high afterwards; only an idle gap or settle() lowers it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      if (decode_byte(b, last)) live_items++;
   endtask

   task automatic send_pair(input logic [7:0] gray, input logic [7:0] run,
                            input logic last);
      send_byte(gray, 1'b0);
      send_byte(run, last);
   endtask

   // Header bytes; cut < 8 ends the stream on header byte number cut.
   task automatic send_header(input logic [31:0] w, input logic [31:0] h,
                              input int unsigned cut);
      for (int unsigned i = 0; i < grld_pkg::HeaderLen; i++) begin
         send_byte(i < 4 ? w[8*i +: 8] : h[8*(i-4) +: 8], i == cut);
         if (i == cut) return;
      end
   endtask

   // n random bytes, the last one closing the stream
   task automatic junk_tail(input int unsigned n);
      for (int unsigned i = 1; i <= n; i++) send_byte(8'($urandom), i == n);
   endtask

   // Stop sending and wait for every owed result.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_out.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_run();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(1, 4));
         1:       return 8'($urandom_range(1, 16));
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------

   // stream ends inside the header
   task automatic test_short_header();
      send_header(32'h00FF_00FF, 32'h0, 2);
      settle();
   endtask

   // width zero, height all ones: everything after the header is dropped
   task automatic test_zero_size();
      send_header(32'h0000_0000, 32'hFFFF_FFFF, grld_pkg::HeaderLen);
      send_byte(8'h05, 1'b1);
      settle();
   endtask

   // 2x1 image, a 255-pixel run gets clamped to 2; the zero byte after the
   // image is complete must be ignored, not taken as a zero run
   task automatic test_clamp_complete();
      send_header(32'd2, 32'd1, grld_pkg::HeaderLen);
      send_pair(8'hFF, 8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      settle();
   endtask

   // zero run length while pixels are still missing
   task automatic test_zero_run();
      send_header(32'd3, 32'd3, grld_pkg::HeaderLen);
      send_pair(8'h07, 8'h00, 1'b0);
      send_byte(8'h09, 1'b1);
      settle();
   endtask

   // largest possible image, one full run, then an odd value byte at the end
   task automatic test_shortfall_odd_byte();
      send_header(32'hFFFF_FFFF, 32'hFFFF_FFFF, grld_pkg::HeaderLen);
      send_pair(8'h80, 8'hFF, 1'b0);
      send_byte(8'h42, 1'b1);
      settle();
   endtask

   // ---------------------------------------------------------------
   // Random streams
   // ---------------------------------------------------------------
   task automatic random_stream();
      int unsigned pick, ending, pairs, extra;
      logic [31:0] w, h;
      logic [7:0]  run;
      logic        last;
      pick     = $urandom_range(0, 99);
      gap_odds = $urandom_range(0, 3) * 3;
      streams++;
      if (pick < 70) begin
         // well-formed image with random content; mostly small sizes
         if ($urandom_range(0, 9) == 0) begin
            w = $urandom_range(1, 700);
            h = 1;
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
         end
         ending = $urandom_range(0, 99);
         if (ending >= 95) begin
            send_header(w, h, $urandom_range(0, grld_pkg::HeaderLen - 1));
            return;
         end
         send_header(w, h, grld_pkg::HeaderLen);
         pairs = (ending < 70) ? 32'hFFFF_FFFF : $urandom_range(0, 3);
         while (pixels_out < pixel_goal && pairs != 0) begin
            run  = pick_run();
            // plain ending: close the stream on the run that fills the image
            last = (ending < 55) && ({56'b0, run} >= pixel_goal - pixels_out);
            send_pair(8'($urandom), run, last);
            if (last) return;
            pairs--;
         end
         if (ending < 70) begin
            // bytes after a complete image are ignored
            junk_tail($urandom_range(1, 4));
         end else if (ending < 80) begin
            send_pair(8'($urandom), pick_run(), 1'b1);
         end else if (ending < 88) begin
            send_byte(8'($urandom), 1'b1);     // odd trailing value byte
         end else begin
            extra = $urandom_range(0, 3);
            send_pair(8'($urandom), 8'h00, extra == 0);
            if (extra != 0) junk_tail(extra);
         end
      end else if (pick < 80) begin
         // zero-size header, other dimension random
         w = $urandom;
         h = $urandom;
         if ($urandom_range(0, 1)) w = '0;
         else h = '0;
         send_header(w, h, grld_pkg::HeaderLen);
         junk_tail($urandom_range(1, 5));
      end else if (pick < 90) begin
         // huge random header: never completes
         w = $urandom;
         h = $urandom;
         send_header(w, h, grld_pkg::HeaderLen);
         repeat ($urandom_range(0, 5)) send_pair(8'($urandom), 8'($urandom), 1'b0);
         junk_tail($urandom_range(1, 2));
      end else begin
         // plain noise, which may end inside the header
         junk_tail($urandom_range(1, 20));
      end
   endtask

   task automatic test_random_streams();
      int unsigned start;
      bit          drained;
      start   = live_items;
      drained = 1'b0;
      while (live_items < start + LiveTarget) begin
         if (live_items >= start + LiveTarget - QuietTail) quiet = 1'b1;
         // once, halfway: stop and let the decoder run dry
         if (!drained && live_items >= start + LiveTarget / 2) begin
            settle();
            drained = 1'b1;
         end
         random_stream();
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_header();
      test_zero_size();
      test_clamp_complete();
      test_zero_run();
      test_shortfall_odd_byte();
      test_random_streams();

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (expected_out.size() != 0) begin
         $error("%0d results never arrived", expected_out.size());
         errors++;
      end

      $display("Decoded %0d streams from %0d bytes; %0d runs checked.",
               streams + 5, sent_items, runs_checked);
      $display("Status results: ok %0d, short header %0d, zero size %0d,",
               status_seen[grld_pkg::ST_OK], status_seen[grld_pkg::ST_SHORT_HEADER],
               status_seen[grld_pkg::ST_ZERO_SIZE]);
      $display("   zero run %0d, shortfall %0d",
               status_seen[grld_pkg::ST_ZERO_RUN], status_seen[grld_pkg::ST_SHORTFALL]);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog: far beyond any correct run
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
